// ===== design/lokzr_pkg.sv =====
// ----------------------------------------------------------------------------
// lokzr_pkg
// Shared types and constants for the longest-ones span block: push control
// bundle between the run tracker and the window accumulator, and the
// configuration register map.
// ----------------------------------------------------------------------------
package lokzr_pkg;

    // Result width on the output stream
    localparam int OUT_W = 17;

    // Configuration register map
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam int CFG_K_W    = 8;

    localparam logic [APB_ADDR_W-1:0] REG_ZERO_RUNS_ALLOWED = 2'd0;
    localparam logic [CFG_K_W-1:0]    K_RESET               = 8'd1;

    // Control for one closed run pushed into the ring
    typedef struct packed {
        logic valid;   // a run is pushed this cycle
        logic is_one;  // the run is a one-run
        logic last;    // final push of the frame
        logic drop;    // window is full, oldest run leaves
    } t_push_ctl;

endpackage

// ===== design/lokzr_ring_mem.sv =====
// ----------------------------------------------------------------------------
// lokzr_ring_mem
// Run length ring: one write port, one read port, registered read data.
// A read and a write of the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module lokzr_ring_mem #(
    parameter int DEPTH = 511,
    parameter int WIDTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lokzr_run_tracker.sv =====
// ----------------------------------------------------------------------------
// lokzr_run_tracker
// Run-length encoder and ring addressing. While enabled, closes runs on bit
// changes, flushes the trailing runs at frame end, and issues one push per
// cycle with the ring read address of the oldest run when the window is full.
// ----------------------------------------------------------------------------
module lokzr_run_tracker #(
    parameter int MAX_LEN = 65536,
    parameter int MAX_K   = 255
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic [lokzr_pkg::CFG_K_W-1:0]          i_k,
    input  logic                                   i_s_valid,
    output logic                                   o_s_ready,
    input  logic                                   i_bit,
    input  logic                                   i_last,
    output lokzr_pkg::t_push_ctl                   o_ctl,
    output logic [$clog2(MAX_LEN+1)-1:0]           o_len,
    output logic [$clog2(2*MAX_K+1)-1:0]           o_waddr,
    output logic [$clog2(2*MAX_K+1)-1:0]           o_raddr
);
    import lokzr_pkg::*;

    localparam int DEPTH = 2 * MAX_K + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int RUN_W = $clog2(DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int K_W   = $clog2(MAX_K + 1);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH_RUN,
        ST_FLUSH_ZERO
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp;
    logic [RUN_W-1:0] r_runs, n_runs;
    logic             r_cur_bit, n_cur_bit;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;

    logic [K_W-1:0]   k_eff;
    logic [RUN_W-1:0] win;
    logic             accept;
    logic             push;
    logic             clear;
    logic             drop;
    logic [RUN_W:0]   wp_x;
    logic [RUN_W:0]   runs_x;
    logic [AW-1:0]    wp_inc;

    assign accept    = i_s_valid && o_s_ready;
    assign o_s_ready = i_en && (r_state == ST_RUN);

    always_comb begin
        if (32'(i_k) > MAX_K) begin
            k_eff = K_W'(MAX_K);
        end else begin
            k_eff = K_W'(i_k);
        end
    end

    assign win  = RUN_W'({k_eff, 1'b1});
    assign drop = (r_runs >= win);

    // Oldest run sits r_runs entries behind the write pointer
    assign wp_x   = (RUN_W+1)'(r_wp);
    assign runs_x = (RUN_W+1)'(r_runs);
    always_comb begin
        if (wp_x >= runs_x) begin
            o_raddr = AW'(wp_x - runs_x);
        end else begin
            o_raddr = AW'(wp_x + (RUN_W+1)'(DEPTH) - runs_x);
        end
    end

    assign wp_inc  = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign o_waddr = r_wp;

    always_comb begin
        n_state   = r_state;
        n_cur_bit = r_cur_bit;
        n_cur_len = r_cur_len;
        push      = 1'b0;
        clear     = 1'b0;
        o_len     = r_cur_len;
        o_ctl     = '0;
        o_ctl.is_one = r_cur_bit;
        o_ctl.drop   = drop;

        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (i_bit != r_cur_bit) begin
                        push      = 1'b1;
                        n_cur_bit = i_bit;
                        n_cur_len = LEN_W'(1);
                    end else if (r_cur_len < LEN_W'(MAX_LEN)) begin
                        n_cur_len = r_cur_len + 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_FLUSH_RUN;
                    end
                end
            end
            ST_FLUSH_RUN: begin
                push       = 1'b1;
                o_ctl.last = r_cur_bit;
                if (r_cur_bit) begin
                    clear = 1'b1;
                end else begin
                    n_state = ST_FLUSH_ZERO;
                end
            end
            ST_FLUSH_ZERO: begin
                // Frame ended on a zero: close it with an empty one-run
                push         = 1'b1;
                o_len        = '0;
                o_ctl.is_one = 1'b1;
                o_ctl.last   = 1'b1;
                clear        = 1'b1;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        o_ctl.valid = push && i_en;

        n_wp   = r_wp;
        n_runs = r_runs;
        if (push) begin
            n_wp = wp_inc;
            if (!drop) begin
                n_runs = r_runs + 1'b1;
            end
        end
        if (clear) begin
            n_state   = ST_RUN;
            n_wp      = '0;
            n_runs    = '0;
            n_cur_bit = 1'b1;
            n_cur_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_wp      <= '0;
            r_runs    <= '0;
            r_cur_bit <= 1'b1;
            r_cur_len <= '0;
        end else if (i_en) begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_runs    <= n_runs;
            r_cur_bit <= n_cur_bit;
            r_cur_len <= n_cur_len;
        end
    end

    a_runs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs <= RUN_W'(DEPTH))
        else $error("window run count exceeds ring depth");

    a_last_starts_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_state == ST_FLUSH_RUN)
        else $error("frame end did not start the flush");

endmodule

// ===== design/lokzr_window_acc.sv =====
// ----------------------------------------------------------------------------
// lokzr_window_acc
// Window accumulator: adds each pushed run, subtracts the oldest run read
// back from the ring when the window is full, tracks the best total at
// one-run closes and holds the frame result in the output register.
// ----------------------------------------------------------------------------
module lokzr_window_acc #(
    parameter int MAX_LEN = 65536,
    parameter int MAX_K   = 255
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  lokzr_pkg::t_push_ctl                  i_ctl,
    input  logic [$clog2(MAX_LEN+1)-1:0]          i_len,
    input  logic [$clog2(MAX_LEN+1)-1:0]          i_old,
    output logic                                  o_stall,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [lokzr_pkg::OUT_W-1:0]           o_span
);
    import lokzr_pkg::*;

    localparam int    DEPTH  = 2 * MAX_K + 1;
    localparam int    LEN_W  = $clog2(MAX_LEN + 1);
    localparam longint WT_MAX = longint'(DEPTH) * longint'(MAX_LEN);
    localparam int    WT_W   = $clog2(WT_MAX + 1);

    t_push_ctl        r_ctl;
    logic [LEN_W-1:0] r_len;
    logic [WT_W-1:0]  r_wt, n_wt;
    logic [WT_W-1:0]  r_best, n_best;
    logic [WT_W-1:0]  best_sat;
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_span;
    logic             fire;

    // Hold the final push while the previous result is still unread
    assign o_stall = r_ctl.valid && r_ctl.last && r_o_valid && !i_ready;
    assign fire    = r_ctl.valid && i_en;

    always_comb begin
        n_wt = r_wt;
        if (r_ctl.drop) begin
            n_wt = r_wt - WT_W'(i_old);
        end
        n_wt = n_wt + WT_W'(r_len);
        n_best = r_best;
        if (r_ctl.is_one && (n_wt > r_best)) begin
            n_best = n_wt;
        end
        best_sat = (n_best > WT_W'(MAX_LEN)) ? WT_W'(MAX_LEN) : n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_wt      <= '0;
            r_best    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_ctl <= i_ctl;
            end
            if (fire) begin
                if (r_ctl.last) begin
                    r_wt   <= '0;
                    r_best <= '0;
                end else begin
                    r_wt   <= n_wt;
                    r_best <= n_best;
                end
            end
            if (fire && r_ctl.last) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= i_len;
        end
        if (fire && r_ctl.last) begin
            r_o_span <= OUT_W'(best_sat);
        end
    end

    assign o_valid = r_o_valid;
    assign o_span  = r_o_span;

    a_best_covers_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_ctl.is_one && !r_ctl.last |=> r_best >= r_wt)
        else $error("best total below window total after one-run close");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_ctl.last |=> r_wt == '0 && r_best == '0 && r_o_valid)
        else $error("frame end did not clear totals or post a result");

    a_drop_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_ctl.drop |-> r_wt >= WT_W'(i_old))
        else $error("dropped run larger than window total");

endmodule

// ===== design/longest_ones_with_k_zero_runs_flipped_top.sv =====
// ----------------------------------------------------------------------------
// longest_ones_with_k_zero_runs_flipped_top
// Longest span of ones with up to k zero-runs flipped, one bit per cycle.
//
// Input stream: one frame bit per transaction in s_axis_tdata[0], with
// s_axis_tlast on the last bit of the frame. Output stream: one result per
// frame in m_axis_tdata[16:0], the longest span saturated at MAX_LEN.
// APB register 0 (byte address 0) holds k, clamped to MAX_K in use.
// Throughput: one bit per cycle inside a frame while not stalled. After
// the last bit the input is held while the run tracker pushes the
// trailing runs into the ring (a second push when the frame ends on a
// zero), one push per cycle through the ring's single write port.
// The flush pushes are registered into the accumulator, and the final
// one loads the output register and raises the output valid.
// Reset: synchronous, clears the frame state and sets k to 1; the ring
// needs no clearing since entries are written before they are read.
// Stall: the result waits in the output register and bits keep flowing;
// only the final push of the next frame holds, and with it the input,
// until the waiting result is taken.
// ----------------------------------------------------------------------------
module longest_ones_with_k_zero_runs_flipped_top #(
    parameter int MAX_LEN = 65536,
    parameter int MAX_K   = 255
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // [0] bit_value
    input  logic                                  s_axis_tlast,  // frame_end
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [23:0]                           m_axis_tdata,  // [16:0] longest_span
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lokzr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lokzr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lokzr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import lokzr_pkg::*;

    localparam int DEPTH = 2 * MAX_K + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [CFG_K_W-1:0] r_k;
    logic               cfg_wr;
    logic               stall;
    logic               en;
    t_push_ctl          push_ctl;
    logic [LEN_W-1:0]   push_len;
    logic [LEN_W-1:0]   old_len;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [OUT_W-1:0]   span;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_ZERO_RUNS_ALLOWED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
        end else if (cfg_wr) begin
            r_k <= pwdata[CFG_K_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_ZERO_RUNS_ALLOWED) begin
            prdata = APB_DATA_W'(r_k);
        end
    end

    assign en = !stall;

    lokzr_run_tracker #(
        .MAX_LEN (MAX_LEN),
        .MAX_K   (MAX_K)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_k       (r_k),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_bit     (s_axis_tdata[0]),
        .i_last    (s_axis_tlast),
        .o_ctl     (push_ctl),
        .o_len     (push_len),
        .o_waddr   (waddr),
        .o_raddr   (raddr)
    );

    lokzr_ring_mem #(
        .DEPTH (DEPTH),
        .WIDTH (LEN_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (push_ctl.valid),
        .i_waddr (waddr),
        .i_wdata (push_len),
        .i_raddr (raddr),
        .o_rdata (old_len)
    );

    lokzr_window_acc #(
        .MAX_LEN (MAX_LEN),
        .MAX_K   (MAX_K)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (push_ctl),
        .i_len   (push_len),
        .i_old   (old_len),
        .o_stall (stall),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_span  (span)
    );

    assign m_axis_tdata = 24'(span);

endmodule

// ===== sim/longest_ones_with_k_zero_runs_flipped_top_tb.sv =====
// ----------------------------------------------------------------------------
// longest_ones_with_k_zero_runs_flipped_top_tb
// Self-checking bench for the longest-ones span block. Frames of bits go in
// on the input stream. A run-length tracker with a sliding window of 2k+1
// runs, kept in the bench, predicts each frame's span, and the span that
// comes out is compared with it. Directed frames cover the register
// extremes, all-zero and all-one frames, k written mid-frame and ring
// wrap-around. Random frames follow under three mixes of source idling
// and sink stalls.
// ----------------------------------------------------------------------------
module longest_ones_with_k_zero_runs_flipped_top_tb;
    import lokzr_pkg::*;

    localparam int SPAN_MAX_LEN  = 65536;
    localparam int SPAN_MAX_K    = 255;
    localparam int RING_SLOTS    = 2 * SPAN_MAX_K + 1;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [0] bit_value, [7:1] zero
    logic                  s_axis_tlast;   // frame_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // [16:0] longest_span, [23:17] zero
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    longest_ones_with_k_zero_runs_flipped_top #(
        .MAX_LEN(SPAN_MAX_LEN),
        .MAX_K  (SPAN_MAX_K)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Span tracker state, mirrored from the block
    logic [OUT_W-1:0]  run_store [RING_SLOTS];
    int unsigned       store_wr_pos;
    int unsigned       runs_held;
    logic              open_run_bit;
    int unsigned       open_run_len;
    longint unsigned   window_sum;
    longint unsigned   best_sum;
    logic [CFG_K_W-1:0] k_setting;

    logic [OUT_W-1:0]  pending_spans [$];
    int                mismatch_count;
    int                spans_checked;
    int                bits_sent;
    int                send_idle_pct;
    int                sink_stall_pct;
    int                cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("longest_ones_with_k_zero_runs_flipped_top verification failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_spans.size() == 0) begin
                $error("longest_span: no result expected, got %0d",
                       m_axis_tdata[OUT_W-1:0]);
                mismatch_count++;
            end else begin
                if (m_axis_tdata[OUT_W-1:0] !== pending_spans[0]) begin
                    $error("longest_span: expected %0d, actual %0d",
                           pending_spans[0], m_axis_tdata[OUT_W-1:0]);
                    mismatch_count++;
                end
                void'(pending_spans.pop_front());
                spans_checked++;
            end
        end
    end

    function automatic void clear_span_frame();
        store_wr_pos = 0;
        runs_held    = 0;
        open_run_bit = 1'b1;
        open_run_len = 0;
        window_sum   = 0;
        best_sum     = 0;
    endfunction

    // Push one closed run; read the oldest before writing the new one
    function automatic void push_closed_run(int unsigned len, logic is_one);
        int unsigned k_eff;
        int unsigned span_width;
        int unsigned oldest;
        k_eff      = (k_setting > SPAN_MAX_K) ? SPAN_MAX_K : k_setting;
        span_width = 2 * k_eff + 1;
        if (runs_held + 1 > span_width) begin
            oldest = (store_wr_pos + RING_SLOTS - (runs_held % RING_SLOTS)) % RING_SLOTS;
            window_sum -= run_store[oldest];
        end else begin
            runs_held++;
        end
        run_store[store_wr_pos] = len[OUT_W-1:0];
        store_wr_pos = (store_wr_pos + 1) % RING_SLOTS;
        window_sum += len;
        if (is_one && window_sum > best_sum)
            best_sum = window_sum;
    endfunction

    function automatic void track_span_bit(logic bit_value, logic frame_end);
        longint unsigned span;
        if (bit_value == open_run_bit) begin
            if (open_run_len < SPAN_MAX_LEN)
                open_run_len++;
        end else begin
            push_closed_run(open_run_len, open_run_bit);
            open_run_bit = bit_value;
            open_run_len = 1;
        end
        if (frame_end) begin
            push_closed_run(open_run_len, open_run_bit);
            // close with an empty one-run when the frame ends on a zero
            if (!open_run_bit)
                push_closed_run(0, 1'b1);
            span = (best_sum > SPAN_MAX_LEN) ? SPAN_MAX_LEN : best_sum;
            pending_spans = {pending_spans, span[OUT_W-1:0]};
            clear_span_frame();
        end
    endfunction

    // All tasks below start and end at a falling edge
    task automatic send_bit(input logic bit_value, input logic frame_end);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, bit_value};
        s_axis_tlast  = frame_end;
        do @(posedge i_clk); while (!s_axis_tready);
        track_span_bit(bit_value, frame_end);
        bits_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
    endtask

    task automatic send_pattern(input string pattern, input logic close_frame);
        for (int i = 0; i < pattern.len(); i++)
            send_bit(pattern[i] == "1", close_frame && (i == pattern.len() - 1));
    endtask

    // Hold until every span is out and the trailing pushes have settled
    task automatic wait_block_idle();
        while (pending_spans.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_zero_runs(input logic [CFG_K_W-1:0] k_value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_ZERO_RUNS_ALLOWED;
        pwdata  = {{(APB_DATA_W-CFG_K_W){1'b0}}, k_value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        k_setting = k_value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = '0;
    endtask

    task automatic send_random_frame(input int max_bits);
        int   n_bits;
        int   run_left;
        logic cur_bit;
        logic noisy;
        n_bits   = $urandom_range(max_bits, 1);
        cur_bit  = 1'($urandom_range(1));
        run_left = $urandom_range(6, 1);
        noisy    = ($urandom_range(9) == 0);
        for (int i = 0; i < n_bits; i++) begin
            if (noisy) begin
                cur_bit = 1'($urandom_range(1));
            end else if (run_left == 0) begin
                cur_bit  = ~cur_bit;
                run_left = $urandom_range(6, 1);
            end
            run_left--;
            // now and then change k between two bits of a frame
            if (i == n_bits / 2 && n_bits > 4 && $urandom_range(15) == 0) begin
                wait_block_idle();
                write_zero_runs(CFG_K_W'($urandom_range(4)));
            end
            send_bit(cur_bit, i == n_bits - 1);
        end
    endtask

    task automatic test_reset_default();
        send_pattern("1", 1'b1);
        send_pattern("0", 1'b1);
        send_pattern("110111", 1'b1);
        send_pattern("0110", 1'b1);
    endtask

    task automatic test_k_extremes();
        wait_block_idle();
        write_zero_runs(8'd0);
        send_pattern("1011", 1'b1);
        send_pattern("000", 1'b1);
        wait_block_idle();
        write_zero_runs(8'd255);
        send_pattern("0101001", 1'b1);
        send_pattern("1111", 1'b1);
    endtask

    task automatic test_k_mid_frame();
        wait_block_idle();
        write_zero_runs(8'd3);
        send_pattern("1010101", 1'b0);
        wait_block_idle();
        write_zero_runs(8'd0);
        send_pattern("011", 1'b1);
        send_pattern("101", 1'b0);
        wait_block_idle();
        write_zero_runs(8'd2);
        send_pattern("001011", 1'b1);
    endtask

    // Enough runs in one frame to wrap the ring at the widest window
    task automatic test_ring_wrap();
        int   n_bits;
        logic cur_bit;
        wait_block_idle();
        write_zero_runs(8'd255);
        n_bits  = 560;
        cur_bit = 1'($urandom_range(1));
        for (int i = 0; i < n_bits; i++) begin
            // toggle on most bits, hold now and then for a two-bit run
            if (i % 16 != 15)
                cur_bit = ~cur_bit;
            send_bit(cur_bit, i == n_bits - 1);
        end
    endtask

    task automatic test_random_frames();
        int mode_bits;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct  = 18;
                    sink_stall_pct = 88;
                end
                1: begin
                    send_idle_pct  = 88;
                    sink_stall_pct = 18;
                end
                default: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 3; phase++) begin
                wait_block_idle();
                case (phase)
                    0: write_zero_runs($urandom_range(1) ? 8'd0 : 8'd255);
                    1: write_zero_runs(CFG_K_W'($urandom_range(8)));
                    default: write_zero_runs(CFG_K_W'($urandom_range(255)));
                endcase
                mode_bits = bits_sent;
                while (bits_sent - mode_bits < 16)
                    send_random_frame(($urandom_range(7) == 0) ? 60 : 16);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        spans_checked  = 0;
        bits_sent      = 0;
        k_setting      = K_RESET;
        foreach (run_store[i]) run_store[i] = '0;
        clear_span_frame();

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_default();
        test_k_extremes();
        test_k_mid_frame();
        test_ring_wrap();
        test_random_frames();

        while (pending_spans.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d frames over %0d bits: k from 0 to 255, k written mid-frame,",
                 spans_checked, bits_sent);
        $display("a ring wrap at the widest window, and source idle / sink stall mixes.");
        if (mismatch_count == 0) begin
            $display("longest_ones_with_k_zero_runs_flipped_top verification clean");
        end else begin
            $display("longest_ones_with_k_zero_runs_flipped_top verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lokzr_pkg.sv
design/lokzr_ring_mem.sv
design/lokzr_run_tracker.sv
design/lokzr_window_acc.sv
design/longest_ones_with_k_zero_runs_flipped_top.sv
sim/longest_ones_with_k_zero_runs_flipped_top_tb.sv
